// ----- hw/rtl/metb_pkg.sv -----
// shared widths, defaults and result status codes of the motion energy time binner
`timescale 1ns / 1ps
`default_nettype none

package metb_pkg;

    localparam int DISP_W    = 16;
    localparam int DIV_W     = 16;
    localparam int DIM_W     = 8;
    localparam int BIN_W     = 16;
    localparam int TOTAL_W   = 48;
    localparam int STATUS_W  = 2;
    localparam int BIN_COUNT_DEF = 16384;

    localparam int SQ_W      = 32;
    localparam int ROOT_W    = 24;
    localparam int WH_W      = 2 * DIM_W;
    localparam int PROD_W    = ROOT_W + WH_W;
    localparam int MUL_A_W   = ROOT_W;
    localparam int MUL_B_W   = WH_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/metb_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module metb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/motion_energy_time_binner.sv -----
// Motion energy time binner: per-second accumulation of scaled motion vector magnitudes.
//
// Input channel (i_valid / o_ready) takes one motion vector per item. Output channel
// (o_valid / i_ready) returns one result per item: the bin index, the bin total after
// the item (8 fraction bits, saturating at 2^48-1) and a status code.
// One item is worked at a time by a small sequencer around one shared 24x16 multiplier,
// a one-bit-per-cycle square root and a two-bit-per-cycle divider.
// A vector that is added passes 3 multiply steps, 24 root steps, 1 scaling multiply,
// 20 divide steps and the bin update before its result is loaded. A vector that is
// skipped or out of range goes from acceptance straight to the output state. o_ready
// returns in the same cycle that the result is loaded, so the input stays closed while
// an added vector is worked.
// After reset the bin store is cleared one entry per cycle, all BIN_COUNT entries (16384
// by default): o_ready stays low until the clear is done and no result is pending.
// A result waits in the output register while the receiver stalls; the next item can
// still be accepted and worked, and it stops only at its own result until the
// register is free.
`timescale 1ns / 1ps
`default_nettype none

module motion_energy_time_binner #(
    parameter int BIN_COUNT = metb_pkg::BIN_COUNT_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [metb_pkg::DISP_W-1:0]    i_disp_x,
    input  wire logic signed [metb_pkg::DISP_W-1:0]    i_disp_y,
    input  wire logic        [metb_pkg::DIV_W-1:0]     i_divisor,
    input  wire logic        [metb_pkg::DIM_W-1:0]     i_block_width,
    input  wire logic        [metb_pkg::DIM_W-1:0]     i_block_height,
    input  wire logic        [metb_pkg::BIN_W-1:0]     i_second_bin,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic             [metb_pkg::BIN_W-1:0]     o_bin_echo,
    output logic             [metb_pkg::TOTAL_W-1:0]   o_bin_total,
    output logic             [metb_pkg::STATUS_W-1:0]  o_status
);

    import metb_pkg::*;

    localparam int ADDR_W     = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = PROD_W / 2;
    localparam int CNT_W      = 5;
    localparam int REM_W      = ROOT_W + 2;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_SQX   = 10'b00_0000_0100,
        S_SQY   = 10'b00_0000_1000,
        S_WH    = 10'b00_0001_0000,
        S_ROOT  = 10'b00_0010_0000,
        S_SCALE = 10'b00_0100_0000,
        S_DIV   = 10'b00_1000_0000,
        S_ACC   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [CNT_W-1:0]    r_cnt;

    logic [DISP_W-1:0]   r_ax, r_ay;
    logic [DIV_W-1:0]    r_div;
    logic [DIM_W-1:0]    r_w, r_h;
    logic [BIN_W-1:0]    r_bin;
    t_status             r_status;
    logic                r_in_range;

    logic [SQ_W-1:0]     r_sq;
    logic [SQ_W-1:0]     r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [WH_W-1:0]     r_wh;
    logic [PROD_W-1:0]   r_dq;
    logic [DIV_W-1:0]    r_drem;
    logic [TOTAL_W-1:0]  r_total;

    logic                r_out_valid;
    logic [BIN_W-1:0]    r_out_echo;
    logic [TOTAL_W-1:0]  r_out_total;
    t_status             r_out_status;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;

    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                root_ge;

    logic [DIV_W:0]      dt1, dt2;
    logic                dge1, dge2;
    logic [DIV_W-1:0]    drem1, drem2;

    logic [TOTAL_W:0]    acc_sum;
    logic [TOTAL_W-1:0]  acc_sat;

    logic                in_fire;
    logic                out_free;
    logic                in_range_now;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [TOTAL_W-1:0]  ram_wr_data;
    logic [TOTAL_W-1:0]  ram_rd_data;

    metb_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (BIN_COUNT),
        .ADDR_W(ADDR_W)
    ) u_bins (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (in_fire),
        .i_rd_addr(i_second_bin[ADDR_W-1:0]),
        .o_rd_data(ram_rd_data)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign in_fire      = i_valid && o_ready;
    assign out_free     = !r_out_valid || i_ready;
    assign in_range_now = ({1'b0, i_second_bin} < 17'(BIN_COUNT));

    // shared multiplier
    always_comb begin
        case (r_state)
            S_SQX: begin
                mul_a = MUL_A_W'(r_ax);
                mul_b = MUL_B_W'(r_ax);
            end
            S_SQY: begin
                mul_a = MUL_A_W'(r_ay);
                mul_b = MUL_B_W'(r_ay);
            end
            S_WH: begin
                mul_a = MUL_A_W'(r_w);
                mul_b = MUL_B_W'(r_h);
            end
            S_SCALE: begin
                mul_a = r_root;
                mul_b = r_wh;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // one root bit per step
    always_comb begin
        rem_sh  = {r_rem, r_rad[SQ_W-1 -: 2]};
        trial   = (REM_W+2)'({r_root, 2'b01});
        root_ge = (rem_sh >= trial);
    end

    // two quotient bits per step
    always_comb begin
        dt1   = {r_drem, r_dq[PROD_W-1]};
        dge1  = (dt1 >= {1'b0, r_div});
        drem1 = dge1 ? DIV_W'(dt1 - {1'b0, r_div}) : dt1[DIV_W-1:0];
        dt2   = {drem1, r_dq[PROD_W-2]};
        dge2  = (dt2 >= {1'b0, r_div});
        drem2 = dge2 ? DIV_W'(dt2 - {1'b0, r_div}) : dt2[DIV_W-1:0];
    end

    always_comb begin
        acc_sum = {1'b0, ram_rd_data} + (TOTAL_W+1)'(r_dq);
        acc_sat = acc_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : acc_sum[TOTAL_W-1:0];
    end

    always_comb begin
        ram_wr_en   = (r_state == S_CLEAR) || (r_state == S_ACC);
        ram_wr_addr = (r_state == S_CLEAR) ? r_clr_addr : r_bin[ADDR_W-1:0];
        ram_wr_data = (r_state == S_CLEAR) ? '0 : acc_sat;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(BIN_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if ((i_divisor == '0) || !in_range_now) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SQX;
                    end
                end
            end
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_WH;
            S_WH:    n_state = S_ROOT;
            S_ROOT: begin
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == S_ROOT || r_state == S_DIV) && (n_state == r_state)) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ax       <= i_disp_x[DISP_W-1] ? DISP_W'(-i_disp_x) : i_disp_x;
            r_ay       <= i_disp_y[DISP_W-1] ? DISP_W'(-i_disp_y) : i_disp_y;
            r_div      <= i_divisor;
            r_w        <= i_block_width;
            r_h        <= i_block_height;
            r_bin      <= i_second_bin;
            r_in_range <= in_range_now;
            if (i_divisor == '0) begin
                r_status <= ST_SKIPPED;
            end else if (!in_range_now) begin
                r_status <= ST_RANGE;
            end else begin
                r_status <= ST_ADDED;
            end
        end
        case (r_state)
            S_SQX: r_sq <= mul_p[SQ_W-1:0];
            S_SQY: begin
                r_rad  <= r_sq + mul_p[SQ_W-1:0];
                r_rem  <= '0;
                r_root <= '0;
            end
            S_WH:  r_wh <= mul_p[WH_W-1:0];
            S_ROOT: begin
                r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
                r_rem  <= root_ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], root_ge};
            end
            S_SCALE: begin
                r_dq   <= mul_p;
                r_drem <= '0;
            end
            S_DIV: begin
                r_dq   <= {r_dq[PROD_W-3:0], dge1, dge2};
                r_drem <= drem2;
            end
            S_ACC: r_total <= acc_sat;
            default: begin
            end
        endcase
        if (r_state == S_OUT && out_free) begin
            r_out_echo   <= r_bin;
            r_out_status <= r_status;
            case (r_status)
                ST_ADDED:   r_out_total <= r_total;
                ST_SKIPPED: r_out_total <= r_in_range ? ram_rd_data : '0;
                ST_RANGE:   r_out_total <= '0;
                default:    r_out_total <= '0;
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_bin_echo  = r_out_echo;
    assign o_bin_total = r_out_total;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

// ----- hw/rtl/metb_checker.sv -----
// port-level checks of the motion energy time binner and their binding
`timescale 1ns / 1ps
`default_nettype none

module metb_checker #(
    parameter int BIN_COUNT = metb_pkg::BIN_COUNT_DEF
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_ready,
    input wire logic                                 o_valid,
    input wire logic                                 i_ready,
    input wire logic [metb_pkg::BIN_W-1:0]           o_bin_echo,
    input wire logic [metb_pkg::TOTAL_W-1:0]         o_bin_total,
    input wire logic [metb_pkg::STATUS_W-1:0]        o_status
);

    import metb_pkg::*;

    // a reset leaves nothing pending and input not ready right after it, as the clear begins
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("output valid or input ready right after reset");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bin_total) && $stable(o_bin_echo)
            && $stable(o_status))
        else $error("stalled result changed");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_RANGE) |-> (o_bin_total == '0))
        else $error("out of range result with nonzero total");

    a_range_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_RANGE) |-> ({1'b0, o_bin_echo} >= 17'(BIN_COUNT)))
        else $error("in range bin flagged out of range");

endmodule

bind motion_energy_time_binner metb_checker #(
    .BIN_COUNT(BIN_COUNT)
) u_metb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_bin_echo (o_bin_echo),
    .o_bin_total(o_bin_total),
    .o_status   (o_status)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for the motion energy time binner, with a bin total scoreboard
`timescale 1ns / 1ps

module tb_top;
    import metb_pkg::*;

    localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int FLOOD_BIN = 7;
    localparam int HOLD_MARK_A = 150;
    localparam int HOLD_MARK_B = 1300;

    typedef struct {
        logic signed [DISP_W-1:0] disp_x;
        logic signed [DISP_W-1:0] disp_y;
        logic        [DIV_W-1:0]  divisor;
        logic        [DIM_W-1:0]  block_width;
        logic        [DIM_W-1:0]  block_height;
        logic        [BIN_W-1:0]  second_bin;
    } motion_vec_t;

    typedef struct {
        logic [BIN_W-1:0]   bin_echo;
        logic [TOTAL_W-1:0] bin_total;
        t_status            status;
    } bin_result_t;

    class bin_energy_tracker;
        logic [TOTAL_W-1:0] bin_store [BIN_COUNT_DEF];
        bin_result_t        pending_totals [$];
        int                 fail_cnt;
        int                 totals_seen;

        function new();
            foreach (bin_store[i]) bin_store[i] = '0;
            fail_cnt = 0;
            totals_seen = 0;
        endfunction

        // floor square root, 24 result bits
        function longint unsigned magnitude_q8(longint unsigned sq);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sq) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void note_vector(motion_vec_t v);
            bin_result_t     r;
            longint          sx;
            longint          sy;
            longint unsigned ax;
            longint unsigned ay;
            longint unsigned mag;
            longint unsigned area;
            longint unsigned sum;
            r.bin_echo = v.second_bin;
            if (v.divisor == 0) begin
                r.status = ST_SKIPPED;
                r.bin_total = (v.second_bin < BIN_COUNT_DEF) ? bin_store[v.second_bin] : '0;
            end else if (v.second_bin >= BIN_COUNT_DEF) begin
                r.status = ST_RANGE;
                r.bin_total = '0;
            end else begin
                sx = v.disp_x;
                sy = v.disp_y;
                ax = (sx < 0) ? -sx : sx;
                ay = (sy < 0) ? -sy : sy;
                mag = magnitude_q8((ax * ax + ay * ay) << 16);
                area = longint'(v.block_width) * longint'(v.block_height);
                sum = bin_store[v.second_bin] + (mag * area) / v.divisor;
                if (sum > TOTAL_MAX) begin
                    sum = TOTAL_MAX;
                end
                bin_store[v.second_bin] = TOTAL_W'(sum);
                r.status = ST_ADDED;
                r.bin_total = TOTAL_W'(sum);
            end
            pending_totals.push_back(r);
        endfunction

        function void check_total(logic [BIN_W-1:0] echo, logic [TOTAL_W-1:0] total,
                                  logic [STATUS_W-1:0] status);
            bin_result_t want;
            totals_seen++;
            if (pending_totals.size() == 0) begin
                $display("%0t: result with no item waiting, bin_echo %0d total %0d status %0d",
                         $time, echo, total, status);
                fail_cnt++;
                return;
            end
            want = pending_totals.pop_front();
            if (echo !== want.bin_echo) begin
                $display("%0t: bin_echo expected %0d actual %0d", $time, want.bin_echo, echo);
                fail_cnt++;
            end
            if (total !== want.bin_total) begin
                $display("%0t: bin_total expected %0d actual %0d (bin %0d)",
                         $time, want.bin_total, total, want.bin_echo);
                fail_cnt++;
            end
            if (status !== STATUS_W'(want.status)) begin
                $display("%0t: status expected %0d actual %0d (bin %0d)",
                         $time, want.status, status, want.bin_echo);
                fail_cnt++;
            end
        endfunction

        function int pending();
            return pending_totals.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [DISP_W-1:0]  i_disp_x;
    logic signed [DISP_W-1:0]  i_disp_y;
    logic        [DIV_W-1:0]   i_divisor;
    logic        [DIM_W-1:0]   i_block_width;
    logic        [DIM_W-1:0]   i_block_height;
    logic        [BIN_W-1:0]   i_second_bin;
    logic                      o_valid;
    logic                      i_ready;
    logic        [BIN_W-1:0]   o_bin_echo;
    logic        [TOTAL_W-1:0] o_bin_total;
    logic        [STATUS_W-1:0] o_status;

    bin_energy_tracker tracker = new();

    motion_energy_time_binner u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_disp_x       (i_disp_x),
        .i_disp_y       (i_disp_y),
        .i_divisor      (i_divisor),
        .i_block_width  (i_block_width),
        .i_block_height (i_block_height),
        .i_second_bin   (i_second_bin),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_bin_echo     (o_bin_echo),
        .o_bin_total    (o_bin_total),
        .o_status       (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_total(o_bin_echo, o_bin_total, o_status);
        end
    end

    task automatic send_item(motion_vec_t v);
        i_valid        <= 1'b1;
        i_disp_x       <= v.disp_x;
        i_disp_y       <= v.disp_y;
        i_divisor      <= v.divisor;
        i_block_width  <= v.block_width;
        i_block_height <= v.block_height;
        i_second_bin   <= v.second_bin;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_vector(v);
    endtask

    task automatic send_fields(int x, int y, int dv, int w, int h, int bin);
        motion_vec_t v;
        v.disp_x = DISP_W'(x);
        v.disp_y = DISP_W'(y);
        v.divisor = DIV_W'(dv);
        v.block_width = DIM_W'(w);
        v.block_height = DIM_W'(h);
        v.second_bin = BIN_W'(bin);
        send_item(v);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return DIM_W'($urandom);
    endfunction

    function automatic logic signed [DISP_W-1:0] pick_disp();
        if ($urandom_range(0, 3) == 0) return DISP_W'(int'($urandom_range(0, 16)) - 8);
        return DISP_W'($urandom);
    endfunction

    function automatic motion_vec_t make_random();
        motion_vec_t v;
        int kind;
        kind = $urandom_range(0, 99);
        v.disp_x = pick_disp();
        v.disp_y = pick_disp();
        v.block_width = pick_dim();
        v.block_height = pick_dim();
        if (kind < 10) begin
            v.divisor = '0;
            v.second_bin = BIN_W'($urandom);
        end else begin
            v.divisor = $urandom_range(0, 1) ? DIV_W'($urandom_range(1, 65535))
                                             : DIV_W'($urandom_range(1, 16));
            if (kind < 20) begin
                v.second_bin = BIN_W'($urandom_range(BIN_COUNT_DEF, 65535));
            end else if (kind < 60) begin
                v.second_bin = BIN_W'($urandom_range(0, 7));
            end else begin
                v.second_bin = BIN_W'($urandom_range(0, BIN_COUNT_DEF - 1));
            end
        end
        return v;
    endfunction

    // near-maximum vectors into one bin, enough to drive it into saturation
    function automatic motion_vec_t make_flood();
        motion_vec_t v;
        int m;
        m = $urandom_range(0, 60);
        v.disp_x = $urandom_range(0, 1) ? DISP_W'(32767 - m) : DISP_W'(m - 32768);
        m = $urandom_range(0, 60);
        v.disp_y = $urandom_range(0, 1) ? DISP_W'(32767 - m) : DISP_W'(m - 32768);
        v.divisor = DIV_W'(1);
        v.block_width = DIM_W'($urandom_range(250, 255));
        v.block_height = DIM_W'($urandom_range(250, 255));
        v.second_bin = BIN_W'(FLOOD_BIN);
        return v;
    endfunction

    task automatic run_stream(int count, bit flood);
        int n;
        int burst;
        int gap;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n < count) begin
                send_item(flood ? make_flood() : make_random());
                burst--;
                n++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin : rx_side
        int  mode;
        int  run_len;
        int  holds_done;
        bit  rdy;
        holds_done = 0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            run_len = $urandom_range(1, 40);
            repeat (run_len) begin
                if ((holds_done == 0 && tracker.totals_seen >= HOLD_MARK_A) ||
                    (holds_done == 1 && tracker.totals_seen >= HOLD_MARK_B)) begin
                    holds_done++;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ($urandom_range(0, 3) != 0);
                endcase
                i_ready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_disp_x       <= '0;
        i_disp_y       <= '0;
        i_divisor      <= '0;
        i_block_width  <= '0;
        i_block_height <= '0;
        i_second_bin   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_fields(0, 0, 1, 255, 255, 0);
        send_fields(-32768, -32768, 1, 255, 255, 1);
        send_fields(32767, 32767, 65535, 255, 255, 1);
        send_fields(-32768, 32767, 1, 0, 255, 2);
        send_fields(32767, -32768, 1, 255, 0, 2);
        send_fields(100, -200, 0, 10, 10, 1);
        send_fields(5, 5, 0, 1, 1, 65535);
        send_fields(7, 7, 5, 3, 3, BIN_COUNT_DEF);
        send_fields(-1, -1, 65535, 255, 255, 65535);
        send_fields(0, 0, 0, 0, 0, BIN_COUNT_DEF - 1);
        send_fields(3, 4, 1, 1, 1, BIN_COUNT_DEF - 1);
        send_fields(1, 0, 3, 1, 1, BIN_COUNT_DEF - 1);
        send_fields(-3, -4, 7, 17, 9, 3);
        send_fields(12345, -23456, 1234, 200, 100, 3);
        send_fields(-1, 0, 65535, 1, 1, 4);
        send_fields(0, -32768, 2, 128, 64, 4);
        send_fields(0, 0, 0, 0, 0, 1);
        send_fields(32767, 0, 1, 255, 255, BIN_COUNT_DEF - 1);
        send_fields(0, 0, 1, 0, 0, 32768);
        send_fields(-32768, 0, 1, 1, 1, 0);
        wait_drained();

        run_stream(500, 1'b0);
        wait_drained();

        run_stream(420, 1'b1);
        // read back the saturated bin, then keep adding to it
        send_fields(0, 0, 0, 0, 0, FLOOD_BIN);
        send_fields(-32768, -32768, 1, 255, 255, FLOOD_BIN);
        wait_drained();

        run_stream(758, 1'b0);
        wait_drained();
        repeat (60) @(posedge i_clk);

        if (tracker.fail_cnt == 0 && tracker.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
